>>> rtl/brpm_pkg.sv
// ----------------------------------------------------------------------------
// brpm_pkg
// types, constants and helpers shared by the beat rate monitor
// ----------------------------------------------------------------------------
package brpm_pkg;

  localparam logic [47:0] MASK48      = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] RATE_SCALE  = 48'd65536000000000;
  localparam logic [47:0] POWER_SCALE = 48'd65536000;
  localparam logic [47:0] UNIT_SCALE  = 48'd1;
  localparam int unsigned PROD_W      = 112;
  localparam int unsigned ENTRY_W     = 128;

  typedef struct packed {
    logic [62:0]        timestamp_ns;
    logic signed [31:0] accuracy;
    logic [47:0]        energy_uj;
    logic signed [31:0] tag;
  } in_t;

  typedef struct packed {
    logic [47:0]        beat_number;
    logic signed [31:0] tag_out;
    logic [62:0]        timestamp_out;
    logic [47:0]        rate_all;
    logic [47:0]        rate_win;
    logic [47:0]        rate_cur;
    logic signed [31:0] acc_all;
    logic signed [31:0] acc_win;
    logic signed [31:0] acc_cur;
    logic [47:0]        pow_all;
    logic [47:0]        pow_win;
    logic [47:0]        pow_cur;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [47:0] k;
    logic [63:0] c;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] q;
  } div_rsp_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_CHK,
    DIV_RUN
  } div_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OP_START,
    ST_OP_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_G_RATE,
    OP_W_RATE,
    OP_I_RATE,
    OP_G_POW,
    OP_W_POW,
    OP_I_POW,
    OP_G_ACC,
    OP_W_ACC
  } op_e;

  // signed mean from magnitude quotient, saturated to 32 bits
  function automatic logic [31:0] acc_clamp(input logic neg, input logic [47:0] q);
    logic [47:0] lim;
    begin
      if (neg) begin
        lim = (q > 48'h8000_0000) ? 48'h8000_0000 : q;
        acc_clamp = 32'(48'd0 - lim);
      end else begin
        lim = (q > 48'h7FFF_FFFF) ? 48'h7FFF_FFFF : q;
        acc_clamp = lim[31:0];
      end
    end
  endfunction

endpackage

>>> rtl/brpm_if.sv
// ----------------------------------------------------------------------------
// brpm_if
// valid/ready request channels for beats and results
// ----------------------------------------------------------------------------
interface brpm_in_if;
  import brpm_pkg::*;
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface brpm_out_if;
  import brpm_pkg::*;
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/brpm_ram.sv
// ----------------------------------------------------------------------------
// brpm_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/brpm_div.sv
// ----------------------------------------------------------------------------
// brpm_div
// iterative a*k/c with 48-bit saturation, 16-bit partial products then
// one quotient bit per cycle
// ----------------------------------------------------------------------------
module brpm_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brpm_pkg::div_req_t  req_i,
  output brpm_pkg::div_rsp_t  rsp_o
);
  import brpm_pkg::*;

  div_state_e          state_q, state_d;
  logic [63:0]         a_q;
  logic [47:0]         k_q;
  logic [63:0]         c_q;
  logic [PROD_W-1:0]   prod_q;
  logic [5:0]          cnt_q;
  logic [63:0]         rem_q;
  logic [47:0]         lo_q;
  logic [47:0]         quo_q;
  logic                done_q;
  logic [63:0]         pp;
  logic                sat;
  logic [64:0]         trial;
  logic                ge;
  logic [64:0]         diff;

  assign pp    = a_q[63:48] * k_q;
  assign sat   = (c_q == 64'd0) || (prod_q[PROD_W-1:48] >= c_q);
  assign trial = {rem_q, lo_q[47]};
  assign ge    = trial >= {1'b0, c_q};
  assign diff  = trial - {1'b0, c_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (req_i.start) state_d = DIV_MUL;
      DIV_MUL:  if (cnt_q == 6'd0) state_d = DIV_CHK;
      DIV_CHK:  state_d = sat ? DIV_IDLE : DIV_RUN;
      DIV_RUN:  if (cnt_q == 6'd0) state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == DIV_CHK) && sat) || ((state_q == DIV_RUN) && (cnt_q == 6'd0));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DIV_IDLE: begin
        if (req_i.start) begin
          a_q    <= req_i.a;
          k_q    <= req_i.k;
          c_q    <= req_i.c;
          prod_q <= '0;
          cnt_q  <= 6'd3;
        end
      end
      DIV_MUL: begin
        prod_q <= {prod_q[PROD_W-17:0], 16'h0} + PROD_W'(pp);
        a_q    <= {a_q[47:0], 16'h0};
        cnt_q  <= cnt_q - 6'd1;
      end
      DIV_CHK: begin
        rem_q <= prod_q[PROD_W-1:48];
        lo_q  <= prod_q[47:0];
        cnt_q <= 6'd47;
        quo_q <= sat ? MASK48 : 48'd0;
      end
      DIV_RUN: begin
        rem_q <= ge ? diff[63:0] : trial[63:0];
        lo_q  <= {lo_q[46:0], 1'b0};
        quo_q <= {quo_q[46:0], ge};
        cnt_q <= cnt_q - 6'd1;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule

>>> rtl/beat_rate_accuracy_power_monitor_top.sv
// ----------------------------------------------------------------------------
// beat_rate_accuracy_power_monitor_top
// per-beat global, window and instant rate, accuracy and power over a ring
// of recent intervals, accuracies and energy deltas
// ----------------------------------------------------------------------------
// sequence: the first beat goes from accept straight to result load; later
// beats pass ring read, update and eight divides on one shared unit (a divide
// ends early when its quotient saturates), then result load. a new beat is
// accepted only after the previous result is loaded into the output register;
// a result held in the output register stalls the next one. reset clears all
// counters and sums and sets window_length to 64; ring contents stay undefined.
module beat_rate_accuracy_power_monitor_top #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  brpm_in_if.sink          in_i,
  brpm_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_data_i
);
  import brpm_pkg::*;

  localparam int unsigned AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned LW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CW  = (LW > 7) ? LW : 7;
  localparam int unsigned ISW = 48 + LW;
  localparam int unsigned ASW = 32 + LW;

  state_e                 state_q, state_d;
  op_e                    op_q;
  logic [6:0]             wl_q;
  logic                   started_q;
  logic [62:0]            first_time_q, last_time_q;
  logic [47:0]            first_energy_q, last_energy_q;
  logic [47:0]            beat_count_q;
  logic [63:0]            acc_total_q;
  logic [ISW-1:0]         isum_q, esum_q;
  logic signed [ASW-1:0]  asum_q;
  logic [AW-1:0]          ring_pos_q, pos_q;
  logic [LW-1:0]          fill_q;
  in_t                    in_q;
  logic [47:0]            bnum_q;
  logic [62:0]            interval_q, elapsed_q;
  logic [47:0]            de_q, tote_q;
  out_t                   res_q;
  logic                   out_valid_q;
  out_t                   out_q;

  logic                   accept;
  logic [LW-1:0]          len;
  logic [AW-1:0]          pos_sel;
  logic [ENTRY_W-1:0]     rdata;
  logic [ENTRY_W-1:0]     wdata;
  logic                   we;
  logic [62:0]            interval, elapsed;
  logic [47:0]            de, tote, entry;
  logic                   full;
  logic [ISW-1:0]         isum_n, esum_n;
  logic signed [ASW-1:0]  asum_n;
  logic [LW-1:0]          fill_n, pos_inc;
  logic [AW-1:0]          pos_n;
  logic [48:0]            beats;
  logic [63:0]            asum_ext;
  logic                   acc_neg;
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic                   out_free;
  out_t                   res_init;
  out_t                   out_d;

  // effective window length
  always_comb begin
    if (wl_q == 7'd0) begin
      len = LW'(1);
    end else if (CW'(wl_q) > CW'(WINDOW_DEPTH)) begin
      len = LW'(WINDOW_DEPTH);
    end else begin
      len = LW'(wl_q);
    end
  end

  assign pos_sel  = (LW'(ring_pos_q) >= len) ? '0 : ring_pos_q;
  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;
  assign beats    = {1'b0, bnum_q} + 49'd1;
  assign asum_ext = 64'(asum_q);

  // ring update
  always_comb begin
    interval = in_q.timestamp_ns - last_time_q;
    elapsed  = in_q.timestamp_ns - first_time_q;
    de       = in_q.energy_uj - last_energy_q;
    tote     = in_q.energy_uj - first_energy_q;
    entry    = (interval > 63'(MASK48)) ? MASK48 : interval[47:0];
    full     = fill_q >= len;
    isum_n   = isum_q + ISW'(entry) - (full ? ISW'(rdata[127:80]) : '0);
    esum_n   = esum_q + ISW'(de) - (full ? ISW'(rdata[47:0]) : '0);
    asum_n   = asum_q + ASW'(in_q.accuracy)
               - (full ? ASW'($signed(rdata[79:48])) : '0);
    fill_n   = full ? fill_q : fill_q + LW'(1);
    pos_inc  = LW'(pos_q) + LW'(1);
    pos_n    = (pos_inc >= len) ? '0 : pos_inc[AW-1:0];
    wdata    = {entry, in_q.accuracy, de};
    we       = (state_q == ST_UPDATE);
  end

  brpm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  // divide operand select
  always_comb begin
    div_req.start = (state_q == ST_OP_START);
    div_req.a     = '0;
    div_req.k     = UNIT_SCALE;
    div_req.c     = '0;
    acc_neg       = 1'b0;
    unique case (op_q)
      OP_G_RATE: begin
        div_req.a = 64'(beats);
        div_req.k = RATE_SCALE;
        div_req.c = 64'(elapsed_q);
      end
      OP_W_RATE: begin
        div_req.a = 64'(fill_q);
        div_req.k = RATE_SCALE;
        div_req.c = 64'(isum_q);
      end
      OP_I_RATE: begin
        div_req.a = 64'd1;
        div_req.k = RATE_SCALE;
        div_req.c = 64'(interval_q);
      end
      OP_G_POW: begin
        div_req.a = 64'(tote_q);
        div_req.k = POWER_SCALE;
        div_req.c = 64'(elapsed_q);
      end
      OP_W_POW: begin
        div_req.a = 64'(esum_q);
        div_req.k = POWER_SCALE;
        div_req.c = 64'(isum_q);
      end
      OP_I_POW: begin
        div_req.a = 64'(de_q);
        div_req.k = POWER_SCALE;
        div_req.c = 64'(interval_q);
      end
      OP_G_ACC: begin
        acc_neg   = acc_total_q[63];
        div_req.a = acc_neg ? (64'd0 - acc_total_q) : acc_total_q;
        div_req.c = 64'(beats);
      end
      OP_W_ACC: begin
        acc_neg   = asum_ext[63];
        div_req.a = acc_neg ? (64'd0 - asum_ext) : asum_ext;
        div_req.c = 64'(fill_q);
      end
      default: ;
    endcase
  end

  brpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = started_q ? ST_READ : ST_DONE;
      ST_READ:     state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_OP_START;
      ST_OP_START: state_d = ST_OP_WAIT;
      ST_OP_WAIT: begin
        if (div_rsp.done) state_d = (op_q == OP_W_ACC) ? ST_DONE : ST_OP_START;
      end
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      op_q           <= OP_G_RATE;
      wl_q           <= 7'd64;
      started_q      <= 1'b0;
      first_time_q   <= '0;
      last_time_q    <= '0;
      first_energy_q <= '0;
      last_energy_q  <= '0;
      beat_count_q   <= '0;
      acc_total_q    <= '0;
      isum_q         <= '0;
      esum_q         <= '0;
      asum_q         <= '0;
      ring_pos_q     <= '0;
      fill_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        wl_q       <= cfg_data_i;
        isum_q     <= '0;
        esum_q     <= '0;
        asum_q     <= '0;
        ring_pos_q <= '0;
        fill_q     <= '0;
      end else if (state_q == ST_UPDATE) begin
        isum_q     <= isum_n;
        esum_q     <= esum_n;
        asum_q     <= asum_n;
        ring_pos_q <= pos_n;
        fill_q     <= fill_n;
      end
      if (accept) begin
        beat_count_q <= beat_count_q + 48'd1;
        acc_total_q  <= acc_total_q + 64'(in_i.payload.accuracy);
        if (!started_q) begin
          started_q      <= 1'b1;
          first_time_q   <= in_i.payload.timestamp_ns;
          last_time_q    <= in_i.payload.timestamp_ns;
          first_energy_q <= in_i.payload.energy_uj;
          last_energy_q  <= in_i.payload.energy_uj;
        end
      end
      if (state_q == ST_UPDATE) begin
        last_time_q   <= in_q.timestamp_ns;
        last_energy_q <= in_q.energy_uj;
        op_q          <= OP_G_RATE;
      end
      if ((state_q == ST_OP_WAIT) && div_rsp.done && (op_q != OP_W_ACC)) begin
        op_q <= op_e'(op_q + 3'd1);
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // first beat result and output word
  always_comb begin
    res_init = '0;
    if (!started_q) begin
      res_init.acc_all = in_i.payload.accuracy;
      res_init.acc_win = in_i.payload.accuracy;
    end
    out_d               = res_q;
    out_d.beat_number   = bnum_q;
    out_d.tag_out       = in_q.tag;
    out_d.timestamp_out = in_q.timestamp_ns;
    out_d.acc_cur       = in_q.accuracy;
  end

  // request payload and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q   <= in_i.payload;
      bnum_q <= beat_count_q;
      pos_q  <= pos_sel;
      res_q  <= res_init;
    end
    if (state_q == ST_UPDATE) begin
      interval_q <= interval;
      elapsed_q  <= elapsed;
      de_q       <= de;
      tote_q     <= tote;
    end
    if ((state_q == ST_OP_WAIT) && div_rsp.done) begin
      case (op_q)
        OP_G_RATE: res_q.rate_all <= div_rsp.q;
        OP_W_RATE: res_q.rate_win <= div_rsp.q;
        OP_I_RATE: res_q.rate_cur <= div_rsp.q;
        OP_G_POW:  res_q.pow_all  <= div_rsp.q;
        OP_W_POW:  res_q.pow_win  <= div_rsp.q;
        OP_I_POW:  res_q.pow_cur  <= div_rsp.q;
        OP_G_ACC:  res_q.acc_all  <= acc_clamp(acc_neg, div_rsp.q);
        OP_W_ACC:  res_q.acc_win  <= acc_clamp(acc_neg, div_rsp.q);
        default: ;
      endcase
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
